FILE: hdl/wua_pkg.sv
// Shared types and constants for the 128-bit unsigned ALU pipeline.
package wua_pkg;

    localparam int unsigned WordW    = 128;
    localparam int unsigned HalfW    = 64;
    localparam int unsigned QuartW   = 32;
    localparam int unsigned ShiftW   = 8;
    localparam int unsigned DivSteps = 128;

    typedef enum logic [2:0] {
        K_ADD     = 3'd0,
        K_SUB     = 3'd1,
        K_MUL     = 3'd2,
        K_DIVMOD  = 3'd3,
        K_SHL_CHK = 3'd4,
        K_SHL_TRN = 3'd5,
        K_MAX     = 3'd6,
        K_MIN     = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_NEGATIVE = 2'd2,
        ST_DIVZERO  = 2'd3
    } t_status;

    // Word state carried down the pipeline
    typedef struct packed {
        t_kind             kind;
        logic [WordW-1:0]  a;
        logic [WordW-1:0]  b;
        logic [WordW-1:0]  res;
        t_status           status;
        logic              less;
        logic              eq;
        logic              mul_ab_ov;
    } t_item;

    // Partial products: three 64x64 products, four 32x32 pieces each
    typedef logic [2:0][3:0][HalfW-1:0] t_pp;

    typedef logic [2:0][WordW-1:0] t_prod;

endpackage

FILE: hdl/wua_if.sv
// Valid/ready channel interfaces for the ALU input and output words.
interface wua_in_if
    import wua_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [2:0]        kind;
    logic [HalfW-1:0]  a_high;
    logic [HalfW-1:0]  a_low;
    logic [HalfW-1:0]  b_high;
    logic [HalfW-1:0]  b_low;
    logic [ShiftW-1:0] shift_amount;

    modport source (output valid, kind, a_high, a_low, b_high, b_low, shift_amount,
                    input ready);
    modport sink   (input valid, kind, a_high, a_low, b_high, b_low, shift_amount,
                    output ready);
endinterface

interface wua_out_if
    import wua_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [HalfW-1:0] result_high;
    logic [HalfW-1:0] result_low;
    logic [HalfW-1:0] rem_high;
    logic [HalfW-1:0] rem_low;
    logic [1:0]       status;
    logic             a_less_b;
    logic             a_equal_b;

    modport source (output valid, result_high, result_low, rem_high, rem_low, status,
                    a_less_b, a_equal_b, input ready);
    modport sink   (input valid, result_high, result_low, rem_high, rem_low, status,
                    a_less_b, a_equal_b, output ready);
endinterface

FILE: hdl/wua_front.sv
// First stage: compare, add, subtract, shift, min/max, divide-by-zero check and multiply partial products.
module wua_front
    import wua_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2:0]        i_kind,
    input  logic [HalfW-1:0]  i_a_high,
    input  logic [HalfW-1:0]  i_a_low,
    input  logic [HalfW-1:0]  i_b_high,
    input  logic [HalfW-1:0]  i_b_low,
    input  logic [ShiftW-1:0] i_shift_amount,
    output logic              o_valid,
    output t_item             o_item,
    output t_pp               o_pp
);

    logic [WordW-1:0] a, b, shl, back, diff;
    logic [WordW:0]   sum;
    logic             less, eq, lose;
    logic [HalfW-1:0] x [3];
    logic [HalfW-1:0] y [3];
    t_item            n_item;
    t_pp              n_pp;
    logic             r_valid;
    t_item            r_item;
    t_pp              r_pp;

    assign a    = {i_a_high, i_a_low};
    assign b    = {i_b_high, i_b_low};
    assign less = a < b;
    assign eq   = a == b;
    assign sum  = {1'b0, a} + {1'b0, b};
    assign diff = a - b;

    // Left shift and its lost-bit check
    assign shl  = i_shift_amount[ShiftW-1] ? '0 : (a << i_shift_amount[ShiftW-2:0]);
    assign back = shl >> i_shift_amount[ShiftW-2:0];
    assign lose = i_shift_amount[ShiftW-1] ? (a != '0) : (back != a);

    // Select result for the operations finished in this stage
    always_comb begin
        n_item.kind      = t_kind'(i_kind);
        n_item.a         = a;
        n_item.b         = b;
        n_item.res       = '0;
        n_item.status    = ST_OK;
        n_item.less      = less;
        n_item.eq        = eq;
        n_item.mul_ab_ov = (i_a_high != '0) && (i_b_high != '0);
        case (t_kind'(i_kind))
            K_ADD: begin
                if (sum[WordW]) begin
                    n_item.res    = a;
                    n_item.status = ST_OVERFLOW;
                end else begin
                    n_item.res = sum[WordW-1:0];
                end
            end
            K_SUB: begin
                if (less) begin
                    n_item.status = ST_NEGATIVE;
                end else begin
                    n_item.res = diff;
                end
            end
            K_MUL: n_item.res = '0;
            K_DIVMOD: begin
                if (b == '0) begin
                    n_item.status = ST_DIVZERO;
                end
            end
            K_SHL_CHK: begin
                if (lose) begin
                    n_item.res    = a;
                    n_item.status = ST_OVERFLOW;
                end else begin
                    n_item.res = shl;
                end
            end
            K_SHL_TRN: n_item.res = shl;
            K_MAX:     n_item.res = (less || eq) ? b : a;
            default:   n_item.res = (less || eq) ? a : b;
        endcase
    end

    // Form 32x32 partial products of al*bl, ah*bl and al*bh
    assign x[0] = i_a_low;
    assign y[0] = i_b_low;
    assign x[1] = i_a_high;
    assign y[1] = i_b_low;
    assign x[2] = i_a_low;
    assign y[2] = i_b_high;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_pp[k][0] = HalfW'(x[k][QuartW-1:0])     * HalfW'(y[k][QuartW-1:0]);
            n_pp[k][1] = HalfW'(x[k][QuartW-1:0])     * HalfW'(y[k][HalfW-1:QuartW]);
            n_pp[k][2] = HalfW'(x[k][HalfW-1:QuartW]) * HalfW'(y[k][QuartW-1:0]);
            n_pp[k][3] = HalfW'(x[k][HalfW-1:QuartW]) * HalfW'(y[k][HalfW-1:QuartW]);
        end
    end

    // Hold on stall, advance otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
            r_pp   <= n_pp;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_pp    = r_pp;

endmodule

FILE: hdl/wua_mul.sv
// Two stages that assemble the 128-bit product and apply the overflow rule.
module wua_mul
    import wua_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    input  t_pp   i_pp,
    output logic  o_valid,
    output t_item o_item
);

    t_prod          n_prod;
    t_prod          r_prod;
    t_item          r_item2;
    t_item          r_item3;
    t_item          n_item3;
    logic [1:0]     r_valid;
    logic [HalfW+1:0] hi_sum;
    logic           ov;

    // Combine the four pieces of each 64x64 product
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_prod[k] = {{HalfW{1'b0}}, i_pp[k][0]}
                      + ({{HalfW{1'b0}}, i_pp[k][1]} << QuartW)
                      + ({{HalfW{1'b0}}, i_pp[k][2]} << QuartW)
                      + ({{HalfW{1'b0}}, i_pp[k][3]} << HalfW);
        end
    end

    // Sum the upper half and check for a product above 128 bits
    assign hi_sum = {2'b00, r_prod[0][WordW-1:HalfW]}
                  + {2'b00, r_prod[1][HalfW-1:0]}
                  + {2'b00, r_prod[2][HalfW-1:0]};
    assign ov = r_item2.mul_ab_ov
             || (r_prod[1][WordW-1:HalfW] != '0)
             || (r_prod[2][WordW-1:HalfW] != '0)
             || (hi_sum[HalfW+1:HalfW] != 2'b00);

    always_comb begin
        n_item3 = r_item2;
        if (r_item2.kind == K_MUL) begin
            if (ov) begin
                n_item3.res    = r_item2.a;
                n_item3.status = ST_OVERFLOW;
            end else begin
                n_item3.res = {hi_sum[HalfW-1:0], r_prod[0][HalfW-1:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= n_prod;
            r_item2 <= i_item;
            r_item3 <= n_item3;
        end
    end

    assign o_valid = r_valid[1];
    assign o_item  = r_item3;

endmodule

FILE: hdl/wua_div.sv
// Restoring divider, one quotient bit per pipeline stage; other words ride along.
module wua_div
    import wua_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_item            i_item,
    output logic             o_valid,
    output t_item            o_item,
    output logic [WordW-1:0] o_rem
);

    logic [DivSteps-1:0] r_valid;
    t_item               r_item [DivSteps];
    logic [WordW-1:0]    r_rem  [DivSteps];
    t_item               n_item [DivSteps];
    logic [WordW-1:0]    n_rem  [DivSteps];

    for (genvar g = 0; g < DivSteps; g++) begin : g_step
        t_item          s_item;
        logic [WordW-1:0] s_rem;
        logic [WordW:0] t, d;

        if (g == 0) begin : g_first
            assign s_item = i_item;
            assign s_rem  = '0;
        end else begin : g_next
            assign s_item = r_item[g-1];
            assign s_rem  = r_rem[g-1];
        end

        // Shift in the next dividend bit and try a subtract
        assign t = {s_rem, s_item.a[WordW-1]};
        assign d = t - {1'b0, s_item.b};

        always_comb begin
            n_item[g]   = s_item;
            n_item[g].a = {s_item.a[WordW-2:0], ~d[WordW]};
            n_rem[g]    = d[WordW] ? t[WordW-1:0] : d[WordW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[DivSteps-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
            r_rem  <= n_rem;
        end
    end

    assign o_valid = r_valid[DivSteps-1];
    assign o_item  = r_item[DivSteps-1];
    assign o_rem   = r_rem[DivSteps-1];

endmodule

FILE: hdl/wide_unsigned_alu_128_top.sv
// Top level of the 128-bit unsigned ALU pipeline.
//
// Input channel i_in takes one word per cycle while i_in.ready is high:
// kind, A as a_high:a_low, B as b_high:b_low and shift_amount. Output
// channel o_out returns one word per input word, in order: result
// (quotient for divmod), remainder, status and the A<B / A==B flags.
// The pipeline has 131 register stages: one front stage, two multiply
// stages and 128 divider stages, one quotient bit each. The divider stage
// count sets the latency; throughput is one word per cycle while o_out.ready
// is high or the last stage is empty.
// All stages advance together. When o_out.ready is low and the last stage
// holds a word, the whole pipeline holds and i_in.ready drops; bubbles are
// not squeezed out, so an empty stage still waits for the stall to clear.
// Reset (synchronous, active low) clears every stage valid bit; words in
// flight are dropped and the payload registers keep stale data.
module wide_unsigned_alu_128_top
    import wua_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    wua_in_if.sink    i_in,
    wua_out_if.source o_out
);

    logic             en;
    logic             front_valid, mul_valid, div_valid;
    t_item            front_item, mul_item, div_item;
    t_pp              front_pp;
    logic [WordW-1:0] div_rem;
    logic             quot_sel;
    logic [WordW-1:0] fin_res, fin_rem;

    // Advance unless the last stage holds a word the sink refuses
    assign en         = !div_valid || o_out.ready;
    assign i_in.ready = en;

    wua_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_in.valid),
        .i_kind         (i_in.kind),
        .i_a_high       (i_in.a_high),
        .i_a_low        (i_in.a_low),
        .i_b_high       (i_in.b_high),
        .i_b_low        (i_in.b_low),
        .i_shift_amount (i_in.shift_amount),
        .o_valid        (front_valid),
        .o_item         (front_item),
        .o_pp           (front_pp)
    );

    wua_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_item  (front_item),
        .i_pp    (front_pp),
        .o_valid (mul_valid),
        .o_item  (mul_item)
    );

    wua_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mul_valid),
        .i_item  (mul_item),
        .o_valid (div_valid),
        .o_item  (div_item),
        .o_rem   (div_rem)
    );

    // Pick quotient and remainder for a valid divide, else the carried result
    assign quot_sel = (div_item.kind == K_DIVMOD) && (div_item.status == ST_OK);
    assign fin_res  = quot_sel ? div_item.a : div_item.res;
    assign fin_rem  = quot_sel ? div_rem : '0;

    assign o_out.valid       = div_valid;
    assign o_out.result_high = fin_res[WordW-1:HalfW];
    assign o_out.result_low  = fin_res[HalfW-1:0];
    assign o_out.rem_high    = fin_rem[WordW-1:HalfW];
    assign o_out.rem_low     = fin_rem[HalfW-1:0];
    assign o_out.status      = div_item.status;
    assign o_out.a_less_b    = div_item.less;
    assign o_out.a_equal_b   = div_item.eq;

endmodule
